// File: src/qybc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qybc_pkg
// Shared constants and types for the quaternion yaw bias corrector.
// ----------------------------------------------------------------------------
package qybc_pkg;

    localparam int QUAT_FRAC_BITS  = 14;
    localparam int ANGLE_FRAC_BITS = 13;
    localparam int CORDIC_STEPS    = 16;

    localparam int DATA_W  = 16;                          // quaternion / angle fields
    localparam int CORD_W  = 34;                          // Q2.30 working width plus headroom
    localparam int ACC_W   = 2 * DATA_W + 1;              // product sum
    localparam int STEP_W  = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
    localparam int ANG_SHIFT = 29 - ANGLE_FRAC_BITS;
    localparam int COS_SHIFT = 30 - QUAT_FRAC_BITS;

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam logic [APB_AW-1:0] ADDR_MAX_BIAS = 3'd0;
    localparam logic [APB_AW-1:0] ADDR_CORR_EN  = 3'd4;

    localparam logic OP_BIAS   = 1'b0;
    localparam logic OP_ROTATE = 1'b1;

    localparam logic signed [CORD_W-1:0] CORDIC_GAIN_INV = 34'sd652032874;
    localparam logic signed [CORD_W-1:0] PI_Q30          = 34'sd3373259426;
    localparam logic signed [CORD_W-1:0] HALF_PI_Q30     = 34'sd1686629713;

    localparam logic signed [DATA_W-1:0] Q_ONE = DATA_W'(1 << QUAT_FRAC_BITS);

    typedef logic signed [DATA_W-1:0] sample_t;
    typedef logic signed [CORD_W-1:0] cord_t;

    // atan(2^-i) in Q30
    localparam cord_t ATAN_Q30 [32] = '{
        34'sd843314857, 34'sd497837829, 34'sd263043837, 34'sd133525159,
        34'sd67021687,  34'sd33543516,  34'sd16775851,  34'sd8388437,
        34'sd4194283,   34'sd2097149,   34'sd1048576,   34'sd524288,
        34'sd262144,    34'sd131072,    34'sd65536,     34'sd32768,
        34'sd16384,     34'sd8192,      34'sd4096,      34'sd2048,
        34'sd1024,      34'sd512,       34'sd256,       34'sd128,
        34'sd64,        34'sd32,        34'sd16,        34'sd8,
        34'sd4,         34'sd2,         34'sd1,         34'sd0
    };

endpackage

// File: src/quaternion_yaw_bias_corrector_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_yaw_bias_corrector_unit
// Stores a yaw bias as cos/sin of minus half the angle and pre-multiplies
// quaternions by the matching rotation about the world Y axis.
// ----------------------------------------------------------------------------
// A bias update (op 0) with the bias flag set clamps the angle to +-max_bias
// and runs a CORDIC of CORDIC_STEPS micro-rotations, one per cycle, through a
// single shift/add stage, during which the input port is busy; with the flag
// clear it clears the bias. No result is produced. A rotate item (op 1) is
// passed through or corrected by the single 16x16 multiplier forming the eight
// products one per cycle into an accumulator. A result waits in the output
// register until taken; the block stalls before writing the next one.
// Registers: max_bias at 0x0, correction_enable at 0x4, written over APB.
// ----------------------------------------------------------------------------
module quaternion_yaw_bias_corrector_unit
    import qybc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_AW-1:0]     paddr,
    input  logic [APB_DW-1:0]     pwdata,
    output logic [APB_DW-1:0]     prdata,
    output logic                  pready,
    // input channel
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_op,
    input  logic                  s_bias_flag,
    input  logic signed [15:0]    s_yaw_angle,
    input  logic signed [15:0]    s_quat_w,
    input  logic signed [15:0]    s_quat_x,
    input  logic signed [15:0]    s_quat_y,
    input  logic signed [15:0]    s_quat_z,
    // result channel
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic signed [15:0]    m_out_w,
    output logic signed [15:0]    m_out_x,
    output logic signed [15:0]    m_out_y,
    output logic signed [15:0]    m_out_z,
    output logic                  m_corrected
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PREP = 3'd1;
    localparam logic [2:0] ST_CORD = 3'd2;
    localparam logic [2:0] ST_FIN  = 3'd3;
    localparam logic [2:0] ST_MAC  = 3'd4;
    localparam logic [2:0] ST_RND  = 3'd5;
    localparam logic [2:0] ST_OUT  = 3'd6;

    function automatic sample_t rnd_sat(input cord_t v, input int unsigned sh);
        cord_t t;
        t = (v + (cord_t'(1) <<< (sh - 1))) >>> sh;
        if (t > cord_t'(Q_ONE))
            return Q_ONE;
        else if (t < -cord_t'(Q_ONE))
            return -Q_ONE;
        else
            return t[DATA_W-1:0];
    endfunction

    // configuration
    logic [14:0] max_bias_reg;
    logic        corr_en_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_bias_reg <= 15'd1430;
            corr_en_reg  <= 1'b1;
        end else if (cfg_wr) begin
            if (paddr == ADDR_MAX_BIAS) max_bias_reg <= pwdata[14:0];
            if (paddr == ADDR_CORR_EN)  corr_en_reg  <= pwdata[0];
        end
    end

    always_comb begin
        prdata = '0;
        unique case (paddr)
            ADDR_MAX_BIAS: prdata = {17'd0, max_bias_reg};
            ADDR_CORR_EN:  prdata = {31'd0, corr_en_reg};
            default:       prdata = '0;
        endcase
    end

    // state
    logic [2:0]        state_reg, state_next;
    logic              bias_valid_reg;
    sample_t           bias_angle_reg;
    sample_t           half_cos_reg;
    sample_t           half_sin_reg;
    cord_t             x_reg, y_reg, z_reg;
    logic              flip_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic [2:0]        mac_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic              rnd_pend_reg;
    logic [1:0]        rnd_idx_reg;
    sample_t           q_reg   [4];
    sample_t           res_reg [4];
    logic              corr_reg;

    logic              m_valid_reg;
    sample_t           m_out_reg [4];
    logic              m_corr_reg;

    logic s_fire;
    assign s_ready = (state_reg == ST_IDLE);
    assign s_fire  = s_valid && s_ready;

    // clamp of the incoming angle
    logic signed [16:0] lim, ang_ext, ang_clamped;
    always_comb begin
        lim     = {2'b00, max_bias_reg};
        ang_ext = {s_yaw_angle[15], s_yaw_angle};
        if (ang_ext > lim)
            ang_clamped = lim;
        else if (ang_ext < -lim)
            ang_clamped = -lim;
        else
            ang_clamped = ang_ext;
    end

    // theta = -angle/2 in Q30, folded into +-pi/2 in ST_PREP
    cord_t theta;
    assign theta = -(cord_t'(bias_angle_reg) <<< ANG_SHIFT);

    // shared micro-rotation stage
    cord_t dx, dy, atan_c;
    assign dx     = y_reg >>> cnt_reg;
    assign dy     = x_reg >>> cnt_reg;
    assign atan_c = ATAN_Q30[5'(cnt_reg)];

    cord_t x_fin, y_fin;
    assign x_fin = flip_reg ? -x_reg : x_reg;
    assign y_fin = flip_reg ? -y_reg : y_reg;

    // multiply-accumulate operand selection
    sample_t coef, comp;
    logic    neg;
    logic signed [2*DATA_W-1:0] prod;
    logic signed [ACC_W-1:0]    acc_next;

    always_comb begin
        coef = mac_reg[0] ? half_sin_reg : half_cos_reg;
        comp = q_reg[0];
        neg  = 1'b0;
        case (mac_reg)
            3'd0: comp = q_reg[0];
            3'd1: begin comp = q_reg[2]; neg = 1'b1; end
            3'd2: comp = q_reg[1];
            3'd3: comp = q_reg[3];
            3'd4: comp = q_reg[2];
            3'd5: comp = q_reg[0];
            3'd6: comp = q_reg[3];
            3'd7: begin comp = q_reg[1]; neg = 1'b1; end
            default: comp = q_reg[0];
        endcase
        prod     = coef * comp;
        acc_next = (mac_reg[0] ? acc_reg : '0)
                 + (neg ? -ACC_W'(prod) : ACC_W'(prod));
    end

    logic passthru;
    assign passthru = !bias_valid_reg || (bias_angle_reg == '0) || !corr_en_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_fire) begin
                if (s_op == OP_ROTATE)
                    state_next = passthru ? ST_OUT : ST_MAC;
                else if (s_bias_flag)
                    state_next = ST_PREP;
            end
            ST_PREP: state_next = ST_CORD;
            ST_CORD: if (cnt_reg == STEP_W'(CORDIC_STEPS - 1)) state_next = ST_FIN;
            ST_FIN:  state_next = ST_IDLE;
            ST_MAC:  if (mac_reg == 3'd7) state_next = ST_RND;
            ST_RND:  state_next = ST_OUT;
            ST_OUT:  if (!m_valid_reg || m_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            bias_valid_reg <= 1'b0;
            bias_angle_reg <= '0;
            half_cos_reg   <= Q_ONE;
            half_sin_reg   <= '0;
            rnd_pend_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg    <= state_next;
            rnd_pend_reg <= (state_reg == ST_MAC) && mac_reg[0];

            if (state_reg == ST_IDLE && s_fire && s_op == OP_BIAS) begin
                if (s_bias_flag) begin
                    bias_valid_reg <= 1'b1;
                    bias_angle_reg <= ang_clamped[15:0];
                end else begin
                    bias_valid_reg <= 1'b0;
                    bias_angle_reg <= '0;
                    half_cos_reg   <= Q_ONE;
                    half_sin_reg   <= '0;
                end
            end

            if (state_reg == ST_FIN) begin
                half_cos_reg <= rnd_sat(x_fin, COS_SHIFT);
                half_sin_reg <= rnd_sat(y_fin, COS_SHIFT);
            end

            if (state_reg == ST_OUT && (!m_valid_reg || m_ready))
                m_valid_reg <= 1'b1;
            else if (m_ready)
                m_valid_reg <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_fire) begin
            q_reg[0]   <= s_quat_w;
            q_reg[1]   <= s_quat_x;
            q_reg[2]   <= s_quat_y;
            q_reg[3]   <= s_quat_z;
            res_reg[0] <= s_quat_w;
            res_reg[1] <= s_quat_x;
            res_reg[2] <= s_quat_y;
            res_reg[3] <= s_quat_z;
            corr_reg   <= !passthru;
            mac_reg    <= '0;
        end

        if (state_reg == ST_PREP) begin
            x_reg   <= CORDIC_GAIN_INV;
            y_reg   <= '0;
            cnt_reg <= '0;
            if (theta > HALF_PI_Q30) begin
                z_reg    <= theta - PI_Q30;
                flip_reg <= 1'b1;
            end else if (theta < -HALF_PI_Q30) begin
                z_reg    <= theta + PI_Q30;
                flip_reg <= 1'b1;
            end else begin
                z_reg    <= theta;
                flip_reg <= 1'b0;
            end
        end

        if (state_reg == ST_CORD) begin
            cnt_reg <= cnt_reg + 1'b1;
            if (!z_reg[CORD_W-1]) begin
                x_reg <= x_reg - dx;
                y_reg <= y_reg + dy;
                z_reg <= z_reg - atan_c;
            end else begin
                x_reg <= x_reg + dx;
                y_reg <= y_reg - dy;
                z_reg <= z_reg + atan_c;
            end
        end

        if (state_reg == ST_MAC) begin
            acc_reg     <= acc_next;
            mac_reg     <= mac_reg + 1'b1;
            rnd_idx_reg <= mac_reg[2:1];
        end

        // a completed sum is rounded in the cycle after it lands
        if (rnd_pend_reg)
            res_reg[rnd_idx_reg] <= rnd_sat(CORD_W'(acc_reg), QUAT_FRAC_BITS);

        if (state_reg == ST_OUT && (!m_valid_reg || m_ready)) begin
            m_out_reg[0] <= res_reg[0];
            m_out_reg[1] <= res_reg[1];
            m_out_reg[2] <= res_reg[2];
            m_out_reg[3] <= res_reg[3];
            m_corr_reg   <= corr_reg;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_out_w     = m_out_reg[0];
    assign m_out_x     = m_out_reg[1];
    assign m_out_y     = m_out_reg[2];
    assign m_out_z     = m_out_reg[3];
    assign m_corrected = m_corr_reg;

endmodule

// File: src/qybc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qybc_checker
// Port-level checks for the yaw bias corrector, bound to the top level.
// ----------------------------------------------------------------------------
module qybc_checker
    import qybc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  logic                  s_op,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  logic signed [15:0]    m_out_w,
    input  logic signed [15:0]    m_out_x,
    input  logic signed [15:0]    m_out_y,
    input  logic signed [15:0]    m_out_z,
    input  logic                  m_corrected
);

    // an accepted rotate transaction keeps the unit busy in the cycle after
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_op == OP_ROTATE |=> !s_ready)
        else $error("input accepted on consecutive cycles");

    // a bias update never produces a result straight away
    a_bias_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_op == OP_BIAS && !m_valid |=> !m_valid)
        else $error("result appeared after a bias update");

    // a stalled result holds
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_w) && $stable(m_out_x)
                                && $stable(m_out_y) && $stable(m_out_z)
                                && $stable(m_corrected))
        else $error("result changed while stalled");

    // corrected components are saturated to one
    a_corrected_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_corrected |->
            m_out_w <= Q_ONE && m_out_w >= -Q_ONE && m_out_x <= Q_ONE && m_out_x >= -Q_ONE
            && m_out_y <= Q_ONE && m_out_y >= -Q_ONE && m_out_z <= Q_ONE
            && m_out_z >= -Q_ONE)
        else $error("corrected component out of range");

    // reset empties the output register
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind quaternion_yaw_bias_corrector_unit qybc_checker u_qybc_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .s_op        (s_op),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_out_w     (m_out_w),
    .m_out_x     (m_out_x),
    .m_out_y     (m_out_y),
    .m_out_z     (m_out_z),
    .m_corrected (m_corrected)
);
